@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by pixel_to_temperature_core; clock is clk, reset is rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PTT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PTT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ptt_pkg.sv @@
`default_nettype none
package ptt_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_RAW_OFFSET    = 3'd0;
  localparam logic [2:0] REG_RAW_GAIN      = 3'd1;
  localparam logic [2:0] REG_SIGNAL_GAIN   = 3'd2;
  localparam logic [2:0] REG_SIGNAL_OFFSET = 3'd3;
  localparam logic [2:0] REG_PLANCK_R      = 3'd4;
  localparam logic [2:0] REG_PLANCK_B      = 3'd5;
  localparam logic [2:0] REG_PLANCK_F      = 3'd6;
  localparam logic [2:0] REG_GUARD         = 3'd7;

  // Fixed-point constants (Q24.24 unless noted)
  localparam logic signed [63:0] ONE_Q24   = 64'sd16777216;
  localparam logic signed [63:0] SAT_LIM   = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic [61:0]        SAT_MAG   = 62'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [46:0]        GUARD_RST = 47'd16780571;
  // ln(2) in Q0.64
  localparam logic [63:0]        LN2_Q64   = 64'hB172_17F7_D1CF_79AB;

  // Per-transaction flags riding alongside the late pipeline
  typedef struct packed {
    logic no_signal;
    logic zero_k;
  } ptt_flags_t;

endpackage
`default_nettype wire

@@ hw/rtl/ptt_mul.sv @@
`default_nettype none
// Two-stage 64x64 unsigned multiplier: 32x32 partial products, then sum.
module ptt_mul #(
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          v_i,
  input  wire logic [63:0]   a_i,
  input  wire logic [63:0]   b_i,
  input  wire logic [SW-1:0] sb_i,
  output logic               v_o,
  output logic [127:0]       p_o,
  output logic [SW-1:0]      sb_o
);

  logic [63:0]   ll_r, lh_r, hl_r, hh_r;
  logic          v1_r, v2_r;
  logic [SW-1:0] sb1_r, sb2_r;
  logic [127:0]  p_r;
  logic [127:0]  p_nxt;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v_i;
      v2_r <= v1_r;
    end
  end

  // Form partial products
  always_ff @(posedge clk) begin
    ll_r  <= a_i[31:0]  * b_i[31:0];
    lh_r  <= a_i[31:0]  * b_i[63:32];
    hl_r  <= a_i[63:32] * b_i[31:0];
    hh_r  <= a_i[63:32] * b_i[63:32];
    sb1_r <= sb_i;
  end

  // Sum partial products
  always_comb begin
    p_nxt = {hh_r, ll_r} + ({64'b0, lh_r} << 32) + ({64'b0, hl_r} << 32);
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    sb2_r <= sb1_r;
  end

  assign v_o  = v2_r;
  assign p_o  = p_r;
  assign sb_o = sb2_r;

endmodule
`default_nettype wire

@@ hw/rtl/ptt_div.sv @@
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, quotient saturates
// to all ones when it does not fit in QW bits (also for a zero divisor with a
// nonzero dividend); zero over zero gives zero.
module ptt_div #(
  parameter int NW = 73,
  parameter int DW = 48,
  parameter int QW = 62,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          v_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] sb_i,
  output logic               v_o,
  output logic [QW-1:0]      q_o,
  output logic [SW-1:0]      sb_o
);

  localparam int CW = NW + DW + QW;

  logic [NW-1:0] rem_r [0:QW];
  logic [DW-1:0] den_r [0:QW];
  logic [QW-1:0] q_r   [0:QW];
  logic          sat_r [0:QW];
  logic [SW-1:0] sb_r  [0:QW];
  logic          v_r   [0:QW];
  logic          sat_nxt;

  // Detect overflow of the quotient up front
  always_comb begin
    sat_nxt = (num_i != '0) &&
              ({{(CW-NW){1'b0}}, num_i} >= {{(CW-DW-QW){1'b0}}, den_i, {QW{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= num_i;
    den_r[0] <= den_i;
    q_r[0]   <= '0;
    sat_r[0] <= sat_nxt;
    sb_r[0]  <= sb_i;
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int Bit = QW - k;
    logic [NW-1:0] den_ext;
    logic          ge;
    logic [NW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    always_comb begin
      den_ext = {{(NW-DW){1'b0}}, den_r[k-1]};
      ge      = (den_r[k-1] != '0) && ((rem_r[k-1] >> Bit) >= den_ext);
      rem_nxt = ge ? (rem_r[k-1] - (den_ext << Bit)) : rem_r[k-1];
      q_nxt      = q_r[k-1];
      q_nxt[Bit] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      den_r[k] <= den_r[k-1];
      q_r[k]   <= q_nxt;
      sat_r[k] <= sat_r[k-1];
      sb_r[k]  <= sb_r[k-1];
    end
  end

  assign v_o  = v_r[QW];
  assign q_o  = sat_r[QW] ? {QW{1'b1}} : q_r[QW];
  assign sb_o = sb_r[QW];

endmodule
`default_nettype wire

@@ hw/rtl/ptt_log.sv @@
`default_nettype none
// Natural log in Q.32 of a Q24.24 value above one: six normalize stages,
// 32 squaring steps of two stages each, then a multiply by ln(2).
module ptt_log #(
  parameter int SW = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          v_i,
  input  wire logic [63:0]   x_i,
  input  wire logic [SW-1:0] sb_i,
  output logic               v_o,
  output logic [63:0]        ln_o,
  output logic [SW-1:0]      sb_o
);

  localparam int NS  = 6;
  localparam int FB  = 32;
  localparam int LGW = 38;

  logic [63:0]   nv_r  [0:NS];
  logic [5:0]    ns_r  [0:NS];
  logic [SW-1:0] nsb_r [0:NS];
  logic          nvl_r [0:NS];

  wire  [63:0]     m_w  [0:FB];
  wire  [LGW-1:0]  lg_w [0:FB];
  wire  [SW-1:0]   sb_w [0:FB];
  wire             v_w  [0:FB];

  logic [127:0]  pf;

  // Capture the argument
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nvl_r[0] <= 1'b0;
    end else begin
      nvl_r[0] <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    nv_r[0]  <= x_i;
    ns_r[0]  <= '0;
    nsb_r[0] <= sb_i;
  end

  // Normalize: shift the leading one up to bit 63 in binary steps
  for (genvar k = 1; k <= NS; k++) begin : g_norm
    localparam int Sh = 1 << (NS - k);
    logic          hit;
    logic [63:0]   nv_nxt;
    logic [5:0]    ns_nxt;

    always_comb begin
      hit    = (nv_r[k-1][63 -: Sh] == '0);
      nv_nxt = hit ? (nv_r[k-1] << Sh) : nv_r[k-1];
      ns_nxt = hit ? (ns_r[k-1] + 6'(Sh)) : ns_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nvl_r[k] <= 1'b0;
      end else begin
        nvl_r[k] <= nvl_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      nv_r[k]  <= nv_nxt;
      ns_r[k]  <= ns_nxt;
      nsb_r[k] <= nsb_r[k-1];
    end
  end

  // Mantissa in Q2.62, integer part of log2 from the leading-one position
  assign m_w[0]  = nv_r[NS] >> 1;
  assign lg_w[0] = {6'd39 - ns_r[NS], {FB{1'b0}}};
  assign sb_w[0] = nsb_r[NS];
  assign v_w[0]  = nvl_r[NS];

  // Square the mantissa; an overflow past two yields the next fraction bit
  for (genvar j = 0; j < FB; j++) begin : g_sq
    localparam int Bit = FB - 1 - j;
    logic [127:0]      p;
    logic [LGW+SW-1:0] psb;
    logic              pv;
    logic [63:0]       mm;

    ptt_mul #(.SW(LGW + SW)) u_sq (
      .clk   (clk),
      .rst_n (rst_n),
      .v_i   (v_w[j]),
      .a_i   (m_w[j]),
      .b_i   (m_w[j]),
      .sb_i  ({lg_w[j], sb_w[j]}),
      .v_o   (pv),
      .p_o   (p),
      .sb_o  (psb)
    );

    assign mm          = p[125:62];
    assign m_w[j+1]    = mm[63] ? (mm >> 1) : mm;
    assign lg_w[j+1]   = psb[LGW+SW-1:SW] | (LGW'(mm[63]) << Bit);
    assign sb_w[j+1]   = psb[SW-1:0];
    assign v_w[j+1]    = pv;
  end

  // Scale log2 to ln
  ptt_mul #(.SW(SW)) u_ln2 (
    .clk   (clk),
    .rst_n (rst_n),
    .v_i   (v_w[FB]),
    .a_i   ({{(64-LGW){1'b0}}, lg_w[FB]}),
    .b_i   (ptt_pkg::LN2_Q64),
    .sb_i  (sb_w[FB]),
    .v_o   (v_o),
    .p_o   (pf),
    .sb_o  (sb_o)
  );

  assign ln_o = pf[127:64];

endmodule
`default_nettype wire

@@ hw/rtl/pixel_to_temperature_core.sv @@
`default_nettype none
// Raw radiometric pixel to kelvin, fully pipelined: one transaction per clock.
// The pipeline depth is set by three one-bit-per-stage dividers and the
//   squaring log unit.
// busy is always low; the receiver cannot stall, so results never back up.
// Reset (rst_n, synchronous) clears all valid bits and loads register defaults.
`include "assert_macros.svh"
module pixel_to_temperature_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_raw_pixel,
  output logic             out_valid,
  output logic [31:0]      out_kelvin,
  output logic             out_no_signal,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  // Register stages from the accepting edge to the output register
  localparam int Latency = 238;

  logic signed [47:0] raw_offset_r, raw_gain_r, signal_gain_r, signal_offset_r;
  logic signed [47:0] planck_r_r, planck_b_r, planck_f_r;
  logic [46:0]        guard_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_offset_r    <= '0;
      raw_gain_r      <= 48'(ptt_pkg::ONE_Q24);
      signal_gain_r   <= 48'(ptt_pkg::ONE_Q24);
      signal_offset_r <= '0;
      planck_r_r      <= '0;
      planck_b_r      <= '0;
      planck_f_r      <= 48'(ptt_pkg::ONE_Q24);
      guard_r         <= ptt_pkg::GUARD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ptt_pkg::REG_RAW_OFFSET:    raw_offset_r    <= cfg_data;
        ptt_pkg::REG_RAW_GAIN:      raw_gain_r      <= cfg_data;
        ptt_pkg::REG_SIGNAL_GAIN:   signal_gain_r   <= cfg_data;
        ptt_pkg::REG_SIGNAL_OFFSET: signal_offset_r <= cfg_data;
        ptt_pkg::REG_PLANCK_R:      planck_r_r      <= cfg_data;
        ptt_pkg::REG_PLANCK_B:      planck_b_r      <= cfg_data;
        ptt_pkg::REG_PLANCK_F:      planck_f_r      <= cfg_data;
        ptt_pkg::REG_GUARD:         guard_r         <= cfg_data[46:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Magnitudes of the signed gain and Planck R registers
  logic [47:0] gain_mag, k1_mag, r_mag;
  assign gain_mag = raw_gain_r[47]    ? 48'(-raw_gain_r)    : raw_gain_r;
  assign k1_mag   = signal_gain_r[47] ? 48'(-signal_gain_r) : signal_gain_r;
  assign r_mag    = planck_r_r[47]    ? 48'(-planck_r_r)    : planck_r_r;

  // ---------------- pixel minus offset ----------------
  logic signed [49:0] diff;
  logic [48:0]        diff_mag;
  logic               s0_v_r;
  logic [72:0]        s0_num_r;
  logic [47:0]        s0_den_r;
  logic               s0_neg_r;

  always_comb begin
    diff     = $signed({10'b0, in_raw_pixel, 24'b0}) - 50'(raw_offset_r);
    diff_mag = diff[49] ? 49'(-diff) : diff[48:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_num_r <= {diff_mag, 24'b0};
    s0_den_r <= gain_mag;
    s0_neg_r <= diff[49] ^ raw_gain_r[47];
  end

  // ---------------- power = diff / J1 ----------------
  logic        d1_v;
  logic [61:0] d1_q;
  logic        d1_neg;

  ptt_div #(.NW(73), .DW(48), .QW(62), .SW(1)) u_div_power (
    .clk   (clk),
    .rst_n (rst_n),
    .v_i   (s0_v_r),
    .num_i (s0_num_r),
    .den_i (s0_den_r),
    .sb_i  (s0_neg_r),
    .v_o   (d1_v),
    .q_o   (d1_q),
    .sb_o  (d1_neg)
  );

  // ---------------- K1 * power ----------------
  logic         m1_v;
  logic [127:0] m1_p;
  logic         m1_neg;

  ptt_mul #(.SW(1)) u_mul_gain (
    .clk   (clk),
    .rst_n (rst_n),
    .v_i   (d1_v),
    .a_i   ({16'b0, k1_mag}),
    .b_i   ({2'b0, d1_q}),
    .sb_i  (d1_neg ^ signal_gain_r[47]),
    .v_o   (m1_v),
    .p_o   (m1_p),
    .sb_o  (m1_neg)
  );

  // Object signal = K1*power - K2, saturated
  logic [61:0]        m1_mag;
  logic signed [63:0] m1_s, sig_sum, sig_sat;
  logic               sig_v_r;
  logic [61:0]        sig_mag_r;
  logic               sig_none_r;

  always_comb begin
    m1_mag  = (m1_p[127:86] != '0) ? ptt_pkg::SAT_MAG : m1_p[85:24];
    m1_s    = m1_neg ? -$signed({2'b0, m1_mag}) : $signed({2'b0, m1_mag});
    sig_sum = m1_s - 64'(signal_offset_r);
    if (sig_sum > ptt_pkg::SAT_LIM) begin
      sig_sat = ptt_pkg::SAT_LIM;
    end else if (sig_sum < -ptt_pkg::SAT_LIM) begin
      sig_sat = -ptt_pkg::SAT_LIM;
    end else begin
      sig_sat = sig_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_v_r <= 1'b0;
    end else begin
      sig_v_r <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    sig_mag_r  <= sig_sat[61:0];
    sig_none_r <= (sig_sat <= 64'sd0);
  end

  // ---------------- R / signal ----------------
  logic        d2_v;
  logic [61:0] d2_q;
  logic        d2_none;

  ptt_div #(.NW(72), .DW(62), .QW(62), .SW(1)) u_div_r (
    .clk   (clk),
    .rst_n (rst_n),
    .v_i   (sig_v_r),
    .num_i ({r_mag, 24'b0}),
    .den_i (sig_mag_r),
    .sb_i  (sig_none_r),
    .v_o   (d2_v),
    .q_o   (d2_q),
    .sb_o  (d2_none)
  );

  // Clamp floor: F*guard when F>1, else guard; user must keep registers static
  logic [127:0]       fg_p;
  logic signed [63:0] floor_r;
  logic signed [63:0] floor_nxt;

  ptt_mul #(.SW(1)) u_mul_floor (
    .clk   (clk),
    .rst_n (rst_n),
    .v_i   (1'b1),
    .a_i   ({16'b0, planck_f_r}),
    .b_i   ({17'b0, guard_r}),
    .sb_i  (1'b0),
    .v_o   (),
    .p_o   (fg_p),
    .sb_o  ()
  );

  always_comb begin
    if (64'(planck_f_r) > ptt_pkg::ONE_Q24) begin
      floor_nxt = (fg_p[127:86] != '0) ? ptt_pkg::SAT_LIM : $signed({2'b0, fg_p[85:24]});
    end else begin
      floor_nxt = $signed({17'b0, guard_r});
    end
  end

  always_ff @(posedge clk) begin
    floor_r <= floor_nxt;
  end

  // x = R/signal + F, saturated and clamped from below
  logic signed [63:0] q2_s, x_sum, x_sat, x_clamp;
  logic               x_v_r;
  logic [61:0]        x_r;
  ptt_pkg::ptt_flags_t x_fl_r, x_fl_nxt;

  always_comb begin
    q2_s  = planck_r_r[47] ? -$signed({2'b0, d2_q}) : $signed({2'b0, d2_q});
    x_sum = q2_s + 64'(planck_f_r);
    if (x_sum > ptt_pkg::SAT_LIM) begin
      x_sat = ptt_pkg::SAT_LIM;
    end else if (x_sum < -ptt_pkg::SAT_LIM) begin
      x_sat = -ptt_pkg::SAT_LIM;
    end else begin
      x_sat = x_sum;
    end
    x_clamp            = (x_sat < floor_r) ? floor_r : x_sat;
    x_fl_nxt.no_signal = d2_none;
    x_fl_nxt.zero_k    = (x_clamp <= ptt_pkg::ONE_Q24) || (planck_b_r <= 48'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_v_r <= 1'b0;
    end else begin
      x_v_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_clamp[61:0];
    x_fl_r <= x_fl_nxt;
  end

  // ---------------- ln(x) ----------------
  logic                lg_v;
  logic [63:0]         lg_ln;
  logic [1:0]          lg_sb;

  ptt_log #(.SW(2)) u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .v_i   (x_v_r),
    .x_i   ({2'b0, x_r}),
    .sb_i  (x_fl_r),
    .v_o   (lg_v),
    .ln_o  (lg_ln),
    .sb_o  (lg_sb)
  );

  // ---------------- kelvin = B / ln ----------------
  logic        d3_v;
  logic [31:0] d3_q;
  logic [1:0]  d3_sb;
  ptt_pkg::ptt_flags_t d3_fl;

  ptt_div #(.NW(71), .DW(64), .QW(32), .SW(2)) u_div_kelvin (
    .clk   (clk),
    .rst_n (rst_n),
    .v_i   (lg_v),
    .num_i ({planck_b_r[46:0], 24'b0}),
    .den_i (lg_ln),
    .sb_i  (lg_sb),
    .v_o   (d3_v),
    .q_o   (d3_q),
    .sb_o  (d3_sb)
  );

  assign d3_fl = d3_sb;

  // Output register
  logic        out_v_r;
  logic [31:0] kelvin_r;
  logic        none_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= d3_v;
    end
  end

  always_ff @(posedge clk) begin
    kelvin_r <= (d3_fl.no_signal || d3_fl.zero_k) ? 32'd0 : d3_q;
    none_r   <= d3_fl.no_signal;
  end

  assign out_valid     = out_v_r;
  assign out_kelvin    = kelvin_r;
  assign out_no_signal = none_r;

  // Checks
  `PTT_ASSERT_IMP(a_nosig_zero, out_valid && out_no_signal, out_kelvin == 32'd0, "no_signal with nonzero kelvin")
  `PTT_ASSERT_IMP(a_out_has_src, out_valid, $past(start, Latency), "result without a matching start")
  `PTT_ASSERT_NXT(a_take_start, start && !busy, s0_v_r, "accepted transaction not captured")

endmodule
`default_nettype wire
